// ===== hdl/pdie_pkg.sv =====
// ----------------------------------------------------------------------------
// pdie_pkg
// Shared types and constants of the pulse-distance IR frame encoder.
// ----------------------------------------------------------------------------
package pdie_pkg;

	localparam int CMD_W  = 2;
	localparam int CODE_W = 11;
	localparam int DUR_W  = 12;
	localparam int GAP_W  = 4;
	localparam int REG_W  = 2;
	localparam int DATA_W = 12;

	typedef enum logic [CMD_W-1:0] {
		CMD_TICK   = 2'd0,
		CMD_SEND   = 2'd1,
		CMD_REPEAT = 2'd2,
		CMD_STOP   = 2'd3
	} cmd_t;

	// configuration register indexes
	localparam logic [REG_W-1:0] REG_MARK_LENGTH       = 2'd0;
	localparam logic [REG_W-1:0] REG_SPACE_ZERO_LENGTH = 2'd1;
	localparam logic [REG_W-1:0] REG_SPACE_ONE_LENGTH  = 2'd2;
	localparam logic [REG_W-1:0] REG_GAP_TICKS         = 2'd3;

	// reset values
	localparam logic [DUR_W-1:0] MARK_RST       = 12'd7;
	localparam logic [DUR_W-1:0] SPACE_ZERO_RST = 12'd189;
	localparam logic [DUR_W-1:0] SPACE_ONE_RST  = 12'd287;
	localparam logic [GAP_W-1:0] GAP_RST        = 4'd10;

	typedef struct packed {
		logic             carrier_on;
		logic [DUR_W-1:0] duration;
		logic             busy_res;
		logic             accepted;
	} res_t;

endpackage

// ===== hdl/pulse_distance_ir_encoder_unit.sv =====
// ----------------------------------------------------------------------------
// pulse_distance_ir_encoder_unit
// Pulse-distance IR frame encoder: takes tick/send/repeat/stop commands and
// returns the carrier level and interval length after each one.
// ----------------------------------------------------------------------------
//  channel   signals                                    direction
//  command   cmd_valid cmd_ready cmd code               in
//  result    res_valid res_ready carrier_on duration    out
//            busy_res accepted
//  config    cfg_we cfg_index cfg_data                  in, write only
//
// One command per cycle while cmd_ready is high; the result is registered,
// with the frame state, in the result register (skid register if stalled).
// A two-entry output buffer (result register plus skid) keeps cmd_ready high
// for one stalled result; cmd_ready drops only when both hold.
// Reset (arst_n low) clears the frame state and restores register defaults.
module pulse_distance_ir_encoder_unit #(
	parameter int CODE_BITS = 11
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cmd_valid,
	output logic                        cmd_ready,
	input  logic [pdie_pkg::CMD_W-1:0]  cmd,
	input  logic [pdie_pkg::CODE_W-1:0] code,
	output logic                        res_valid,
	input  logic                        res_ready,
	output logic                        carrier_on,
	output logic [pdie_pkg::DUR_W-1:0]  duration,
	output logic                        busy_res,
	output logic                        accepted,
	input  logic                        cfg_we,
	input  logic [pdie_pkg::REG_W-1:0]  cfg_index,
	input  logic [pdie_pkg::DATA_W-1:0] cfg_data
);
	import pdie_pkg::*;

	localparam int BS_W = $clog2(CODE_BITS + 1);

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_MARK,
		PH_SPACE,
		PH_STOPMARK,
		PH_GAP
	} phase_t;

	// configuration
	logic [DUR_W-1:0] mark_len_q, space0_len_q, space1_len_q;
	logic [GAP_W-1:0] gap_ticks_q;

	// frame state
	phase_t                 phase_q, phase_d;
	logic [CODE_BITS-1:0]   shift_q, shift_d;
	logic [BS_W-1:0]        bits_sent_q, bits_sent_d;
	logic [GAP_W-1:0]       gap_done_q, gap_done_d;
	logic                   toggle_q, toggle_d;
	logic [CODE_BITS-1:0]   stored_q, stored_d;
	logic                   carrier_q, carrier_d;
	logic [DUR_W-1:0]       held_dur_q, held_dur_d;
	logic                   acc_d;

	// output buffer
	logic res_valid_q, skid_valid_q;
	res_t res_q, skid_q, res_new;

	logic cmd_take, out_free;
	logic [BS_W-1:0]  bits_inc;
	logic [GAP_W:0]   gap_inc;
	logic             start_ok;

	assign cmd_take = cmd_valid && cmd_ready;
	assign cmd_ready = !skid_valid_q;
	assign out_free = !res_valid_q || res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mark_len_q   <= MARK_RST;
			space0_len_q <= SPACE_ZERO_RST;
			space1_len_q <= SPACE_ONE_RST;
			gap_ticks_q  <= GAP_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MARK_LENGTH:       mark_len_q   <= cfg_data;
				REG_SPACE_ZERO_LENGTH: space0_len_q <= cfg_data;
				REG_SPACE_ONE_LENGTH:  space1_len_q <= cfg_data;
				REG_GAP_TICKS:         gap_ticks_q  <= cfg_data[GAP_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		phase_d     = phase_q;
		shift_d     = shift_q;
		bits_sent_d = bits_sent_q;
		gap_done_d  = gap_done_q;
		toggle_d    = toggle_q;
		stored_d    = stored_q;
		carrier_d   = carrier_q;
		held_dur_d  = held_dur_q;
		acc_d       = 1'b0;
		bits_inc    = bits_sent_q + 1'b1;
		gap_inc     = {1'b0, gap_done_q} + 1'b1;

		// send stores first, then both send and repeat try to start a frame
		if (cmd_t'(cmd) == CMD_SEND) begin
			stored_d = CODE_BITS'(code);
			if (toggle_q)
				stored_d[CODE_BITS-2] = 1'b1;
		end
		start_ok = (stored_d != '0) && (phase_q == PH_IDLE);

		case (cmd_t'(cmd))
			CMD_TICK: begin
				case (phase_q)
					PH_MARK, PH_STOPMARK: begin
						held_dur_d = mark_len_q;
						carrier_d  = 1'b1;
						phase_d    = (phase_q == PH_MARK) ? PH_SPACE : PH_GAP;
					end
					PH_SPACE: begin
						carrier_d   = 1'b0;
						held_dur_d  = shift_q[CODE_BITS-1] ? space1_len_q : space0_len_q;
						shift_d     = {shift_q[CODE_BITS-2:0], 1'b0};
						bits_sent_d = bits_inc;
						phase_d     = (bits_inc >= BS_W'(CODE_BITS)) ? PH_STOPMARK : PH_MARK;
					end
					PH_GAP: begin
						carrier_d  = 1'b0;
						held_dur_d = space0_len_q;
						gap_done_d = gap_inc[GAP_W-1:0];
						if (gap_inc >= {1'b0, gap_ticks_q}) begin
							bits_sent_d = '0;
							gap_done_d  = '0;
							phase_d     = PH_IDLE;
						end
					end
					default: begin
						carrier_d = 1'b0;
						phase_d   = PH_IDLE;
					end
				endcase
			end
			CMD_SEND, CMD_REPEAT: begin
				if (start_ok) begin
					shift_d     = stored_d;
					bits_sent_d = '0;
					phase_d     = PH_MARK;
					acc_d       = 1'b1;
				end
			end
			default: begin
				// stop is refused while a frame runs
				if (phase_q == PH_IDLE) begin
					toggle_d  = !toggle_q;
					carrier_d = 1'b0;
					acc_d     = 1'b1;
				end
			end
		endcase

		res_new.carrier_on = carrier_d;
		res_new.duration   = held_dur_d;
		res_new.busy_res   = (phase_d != PH_IDLE);
		res_new.accepted   = acc_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			shift_q      <= '0;
			bits_sent_q  <= '0;
			gap_done_q   <= '0;
			toggle_q     <= 1'b1;
			stored_q     <= '0;
			carrier_q    <= 1'b0;
			held_dur_q   <= MARK_RST;
			res_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (cmd_take) begin
				phase_q     <= phase_d;
				shift_q     <= shift_d;
				bits_sent_q <= bits_sent_d;
				gap_done_q  <= gap_done_d;
				toggle_q    <= toggle_d;
				stored_q    <= stored_d;
				carrier_q   <= carrier_d;
				held_dur_q  <= held_dur_d;
			end
			if (out_free) begin
				if (skid_valid_q) begin
					res_valid_q  <= 1'b1;
					skid_valid_q <= 1'b0;
				end else begin
					res_valid_q <= cmd_take;
				end
			end else if (cmd_take) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	// result payload, no reset
	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_valid_q)
				res_q <= skid_q;
			else if (cmd_take)
				res_q <= res_new;
		end else if (cmd_take) begin
			skid_q <= res_new;
		end
	end

	assign res_valid  = res_valid_q;
	assign carrier_on = res_q.carrier_on;
	assign duration   = res_q.duration;
	assign busy_res   = res_q.busy_res;
	assign accepted   = res_q.accepted;

endmodule
